>>> design/umre_pkg.sv
// Shared types and constants for the universal machine register execute block.
// Holds operation codes, fault codes, controller states and command/status structs.
// No dependencies.
`default_nettype none

package umre_pkg;

    // Datapath geometry
    localparam int DATA_W      = 32;
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int CHAR_W      = 8;
    localparam int IMM_VAL_W   = 25;
    localparam int IMM_REG_LSB = 25;
    localparam int CNT_W       = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] BYTE_MAX = 32'd255;

    // Operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_CMOV   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_MUL    = 3'd2,
        KIND_DIV    = 3'd3,
        KIND_NAND   = 3'd4,
        KIND_OUTPUT = 3'd5,
        KIND_INPUT  = 3'd6,
        KIND_LOADI  = 3'd7
    } t_kind;

    // Fault codes reported with each result
    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_DIV_ZERO = 2'd1,
        FAULT_RANGE    = 2'd2
    } t_fault;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_WB,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic mul;
        logic div_start;
        logic div_step;
        logic wb;
        logic load_out;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  vc_zero;
        logic  div_last;
    } t_stat;

endpackage

`default_nettype wire

>>> design/umre_in_if.sv
// Input channel interface: one operation per transaction.
// Carries valid, ready and the operation fields; no dependencies.
`default_nettype none

interface umre_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  reg_a;
    logic [2:0]  reg_b;
    logic [2:0]  reg_c;
    logic [31:0] immediate_word;
    logic [7:0]  in_char;
    logic        in_eof;

    modport source (
        output valid, kind, reg_a, reg_b, reg_c, immediate_word, in_char, in_eof,
        input  ready
    );
    modport sink (
        input  valid, kind, reg_a, reg_b, reg_c, immediate_word, in_char, in_eof,
        output ready
    );
endinterface

`default_nettype wire

>>> design/umre_out_if.sv
// Result channel interface: one result per transaction.
// Carries valid, ready, the emitted character and the fault code; no dependencies.
`default_nettype none

interface umre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_valid;
    logic [1:0] fault;

    modport source (
        output valid, out_char, out_valid, fault,
        input  ready
    );
    modport sink (
        input  valid, out_char, out_valid, fault,
        output ready
    );
endinterface

`default_nettype wire

>>> design/universal_machine_register_execute.sv
// Top level of the universal machine register execute block.
// Depends on umre_pkg, umre_in_if, umre_out_if, umre_ctrl and umre_dp.
//
// Executes one register operation per input transaction over eight 32-bit
// registers that read as zero after reset, and returns exactly one result
// transaction per operation. Operations are handled one at a time: an
// operation is read from the register file, executed and written back before
// the next is taken. Each operation passes through the read, execute and done
// states; multiply adds a write-back state (the product is registered before
// write-back), and divide adds the divider state, in which one quotient bit is
// developed per cycle, before write-back. Divide by zero skips both.
// The result sits in an output register, so the next operation is accepted
// while a result waits; an operation finishing while the output register
// is still full holds until it drains. Divide by zero leaves the destination
// unchanged and reports fault 1; output of a value above 255 emits nothing and
// reports fault 2.
`default_nettype none

module universal_machine_register_execute import umre_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    umre_in_if.sink      i_in,
    umre_out_if.source   o_out
);

    t_cmd  s_cmd;
    t_stat s_stat;

    umre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_vld   (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    umre_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (i_in.kind),
        .i_reg_a          (i_in.reg_a),
        .i_reg_b          (i_in.reg_b),
        .i_reg_c          (i_in.reg_c),
        .i_immediate_word (i_in.immediate_word),
        .i_in_char        (i_in.in_char),
        .i_in_eof         (i_in.in_eof),
        .i_cmd            (s_cmd),
        .o_stat           (s_stat),
        .o_out_char       (o_out.out_char),
        .o_out_valid      (o_out.out_valid),
        .o_fault          (o_out.fault)
    );

`ifndef ASSERT_OFF
    // A faulted result never carries an emitted character
    a_fault_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.fault != FAULT_NONE |-> !o_out.out_valid)
        else $error("faulted result carries a character");

    // Divider iterates only for a divide operation
    a_div_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.div_step |-> s_stat.kind == KIND_DIV)
        else $error("divider stepping for a non-divide operation");

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |-> !o_out.valid || o_out.ready)
        else $error("result register overwritten while full");

    // Write-back only follows multiply or divide
    a_wb_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.wb |-> s_stat.kind == KIND_MUL || s_stat.kind == KIND_DIV)
        else $error("write-back for a single-cycle operation");
`endif

endmodule

`default_nettype wire

>>> design/umre_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module umre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/umre_ctrl.sv
// Controller for the register execute block: sequences read, execute,
// divide iterations, write-back and result hand-off. Depends on umre_pkg.
`default_nettype none

module umre_ctrl import umre_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_vld,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // take no transaction while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_DONE;
                if (i_stat.kind == KIND_MUL) begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_WB;
                end else if (i_stat.kind == KIND_DIV && !i_stat.vc_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free or draining
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end
    end

    assign o_out_vld = r_out_vld;

endmodule

`default_nettype wire

>>> design/umre_dp.sv
// Datapath for the register execute block: operand latch, register file with
// valid bits, ALU, multiplier, bit-serial divider and result registers.
// Depends on umre_pkg and umre_ram.
`default_nettype none

module umre_dp import umre_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [2:0]           i_kind,
    input  wire logic [REG_IDX_W-1:0] i_reg_a,
    input  wire logic [REG_IDX_W-1:0] i_reg_b,
    input  wire logic [REG_IDX_W-1:0] i_reg_c,
    input  wire logic [DATA_W-1:0]    i_immediate_word,
    input  wire logic [CHAR_W-1:0]    i_in_char,
    input  wire logic                 i_in_eof,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output logic [CHAR_W-1:0]         o_out_char,
    output logic                      o_out_valid,
    output logic [1:0]                o_fault
);

    // Latched operation
    t_kind                r_kind;
    logic [REG_IDX_W-1:0] r_a, r_b, r_c;
    logic [DATA_W-1:0]    r_word;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_eof;

    // Register file state
    logic [REG_COUNT-1:0] r_vld;
    logic                 r_vb_ok, r_vc_ok;
    logic [DATA_W-1:0]    s_rd_b, s_rd_c, s_vb, s_vc;

    // Divider / multiplier accumulator
    logic [DATA_W-1:0]    r_quo, r_rem, r_dvs;
    logic [CNT_W-1:0]     r_cnt;
    logic [DATA_W:0]      s_shift, s_diff;
    logic [2*DATA_W-1:0]  s_prod;

    // Pending and output result
    logic [CHAR_W-1:0]    r_och, r_out_char;
    logic                 r_oval, r_out_valid;
    t_fault               r_fault, r_out_fault;
    logic [CHAR_W-1:0]    s_och;
    logic                 s_oval;
    t_fault               s_fault;

    // Write port selection
    logic                 s_alu_we, s_we;
    logic [REG_IDX_W-1:0] s_alu_addr, s_waddr;
    logic [DATA_W-1:0]    s_alu_data, s_wdata;

    // Capture the operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_a    <= i_reg_a;
            r_b    <= i_reg_b;
            r_c    <= i_reg_c;
            r_word <= i_immediate_word;
            r_char <= i_in_char;
            r_eof  <= i_in_eof;
        end
    end

    umre_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (s_we),
        .i_waddr   (s_waddr),
        .i_wdata   (s_wdata),
        .i_re      (i_cmd.read),
        .i_raddr_a (r_b),
        .i_raddr_b (r_c),
        .o_rdata_a (s_rd_b),
        .o_rdata_b (s_rd_c)
    );

    // Track written registers; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_we) begin
            r_vld[s_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_vb_ok <= r_vld[r_b];
            r_vc_ok <= r_vld[r_c];
        end
    end

    assign s_vb = r_vb_ok ? s_rd_b : '0;
    assign s_vc = r_vc_ok ? s_rd_c : '0;

    // ALU operations, written in the execute state
    always_comb begin
        s_alu_we   = 1'b0;
        s_alu_addr = r_a;
        s_alu_data = '0;
        case (r_kind)
            KIND_CMOV: begin
                s_alu_we   = (s_vc != '0);
                s_alu_data = s_vb;
            end
            KIND_ADD: begin
                s_alu_we   = 1'b1;
                s_alu_data = s_vb + s_vc;
            end
            KIND_NAND: begin
                s_alu_we   = 1'b1;
                s_alu_data = ~(s_vb & s_vc);
            end
            KIND_INPUT: begin
                s_alu_we   = 1'b1;
                s_alu_addr = r_c;
                s_alu_data = r_eof ? ALL_ONES : {{(DATA_W-CHAR_W){1'b0}}, r_char};
            end
            KIND_LOADI: begin
                s_alu_we   = 1'b1;
                s_alu_addr = r_word[IMM_REG_LSB +: REG_IDX_W];
                s_alu_data = {{(DATA_W-IMM_VAL_W){1'b0}}, r_word[IMM_VAL_W-1:0]};
            end
            default: begin
                s_alu_we = 1'b0;
            end
        endcase
    end

    assign s_we    = (i_cmd.exec && s_alu_we) || i_cmd.wb;
    assign s_waddr = i_cmd.wb ? r_a : s_alu_addr;
    assign s_wdata = i_cmd.wb ? r_quo : s_alu_data;

    // Multiply and restoring divide, one quotient bit per cycle
    assign s_prod  = s_vb * s_vc;
    assign s_shift = {r_rem, r_quo[DATA_W-1]};
    assign s_diff  = s_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_quo <= s_prod[DATA_W-1:0];
        end else if (i_cmd.div_start) begin
            r_quo <= s_vb;
            r_rem <= '0;
            r_dvs <= s_vc;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!s_diff[DATA_W]) begin
                r_rem <= s_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= s_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    // Result fields for the current operation
    always_comb begin
        s_och   = '0;
        s_oval  = 1'b0;
        s_fault = FAULT_NONE;
        if (r_kind == KIND_OUTPUT) begin
            if (s_vc > BYTE_MAX) begin
                s_fault = FAULT_RANGE;
            end else begin
                s_och  = s_vc[CHAR_W-1:0];
                s_oval = 1'b1;
            end
        end else if (r_kind == KIND_DIV && s_vc == '0) begin
            s_fault = FAULT_DIV_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_och   <= s_och;
            r_oval  <= s_oval;
            r_fault <= s_fault;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_char  <= r_och;
            r_out_valid <= r_oval;
            r_out_fault <= r_fault;
        end
    end

    assign o_out_char      = r_out_char;
    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_out_fault;
    assign o_stat.kind     = r_kind;
    assign o_stat.vc_zero  = (s_vc == '0);
    assign o_stat.div_last = (r_cnt == CNT_W'(DATA_W - 1));

endmodule

`default_nettype wire
